### design/button_debounce_long_press_repeat_defines.svh
// Assertion macros shared by the button qualifier.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// Checked only outside reset.
`define BDLPR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BDLPR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/bdlpr_pkg.sv
package bdlpr_pkg;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_PIN  = 2'd1,
        KIND_INIT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_UP          = 2'd0,
        PH_DOWN        = 2'd1,
        PH_SETTLE_DOWN = 2'd2,
        PH_SETTLE_UP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_HANDLER_ENABLED  = 2'd0,
        REG_DEBOUNCE_TICKS   = 2'd1,
        REG_FIRST_HOLD_TICKS = 2'd2,
        REG_REPEAT_TICKS     = 2'd3
    } reg_index_t;

    localparam int unsigned TICKS_W = 16;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET   = 16'd200;
    localparam logic [TICKS_W-1:0] FIRST_HOLD_RESET = 16'd1000;
    localparam logic [TICKS_W-1:0] REPEAT_RESET     = 16'd250;

    localparam logic EVT_PRESS  = 1'b0;
    localparam logic EVT_REPEAT = 1'b1;

    typedef struct packed {
        kind_t kind;
        logic  pin_level;
    } cmd_t;

    typedef struct packed {
        logic event_level;
        logic event_kind;
    } evt_t;

endpackage

### design/button_debounce_long_press_repeat.sv
// Qualifies an active-low push button: debounce, press detection and long-press repeat.
// The command channel (cmd_valid, cmd_stall, cmd_data) takes one word per timer tick,
// pin-change interrupt or initialise request, each carrying the current pin level.
// The event channel (evt_valid, evt_stall, evt_data) delivers a press or repeat word
// with the level seen when it was reported; most commands produce no word at all.
// A command word sits in the input register, is evaluated against the button phase and
// the 16-bit countdown, and any event lands in the output register, so an event passes
// the input register and then the output register after its command is accepted.
// One command is taken every cycle unless cmd_stall is raised; the single input register
// and the single output register set that figure, and both sides can move in the same cycle.
// When the output register holds a word that the receiver stalls, the command in the
// input register waits and cmd_stall rises until the event word is taken.
// Reset empties both registers, puts the button in the released phase with the
// countdown stopped, and loads the period registers with 200, 1000 and 250 ticks
// with event reporting disabled. The APB-style port writes and reads the four
// registers at byte addresses 0, 4, 8 and 12.
`include "button_debounce_long_press_repeat_defines.svh"

module button_debounce_long_press_repeat (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [bdlpr_pkg::DATA_W-1:0]  pwdata,
    output logic [bdlpr_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  bdlpr_pkg::cmd_t               cmd_data,
    output logic                          evt_valid,
    input  logic                          evt_stall,
    output bdlpr_pkg::evt_t               evt_data
);

    logic                           handler_enabled_reg;
    logic [bdlpr_pkg::TICKS_W-1:0]  debounce_ticks_reg;
    logic [bdlpr_pkg::TICKS_W-1:0]  first_hold_ticks_reg;
    logic [bdlpr_pkg::TICKS_W-1:0]  repeat_ticks_reg;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    bdlpr_pkg::cmd_t                in_word_reg;

    bdlpr_pkg::phase_t              phase_reg;
    bdlpr_pkg::phase_t              phase_next;
    logic [bdlpr_pkg::TICKS_W-1:0]  remaining_reg;
    logic [bdlpr_pkg::TICKS_W-1:0]  remaining_next;
    logic                           running_reg;
    logic                           running_next;

    logic                           evt_valid_reg;
    logic                           evt_valid_next;
    bdlpr_pkg::evt_t                evt_data_reg;
    bdlpr_pkg::evt_t                evt_word;
    logic                           evt_fire;

    logic                           cfg_write;
    logic                           advance;
    logic                           cmd_take;
    logic                           proc;
    logic                           expiring;
    logic                           settling;
    bdlpr_pkg::reg_index_t          reg_sel;

    // A period register that holds zero counts as one tick.
    function automatic logic [bdlpr_pkg::TICKS_W-1:0] period_of(
        input logic [bdlpr_pkg::TICKS_W-1:0] period
    );
        logic [bdlpr_pkg::TICKS_W-1:0] res;
        begin
            res = period;
            if (period == '0)
            begin
                res = {{(bdlpr_pkg::TICKS_W-1){1'b0}}, 1'b1};
            end
            return res;
        end
    endfunction

    assign pready    = 1'b1;
    assign reg_sel   = bdlpr_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_enabled_reg  <= 1'b0;
            debounce_ticks_reg   <= bdlpr_pkg::DEBOUNCE_RESET;
            first_hold_ticks_reg <= bdlpr_pkg::FIRST_HOLD_RESET;
            repeat_ticks_reg     <= bdlpr_pkg::REPEAT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                bdlpr_pkg::REG_HANDLER_ENABLED:  handler_enabled_reg  <= pwdata[0];
                bdlpr_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= pwdata[15:0];
                bdlpr_pkg::REG_FIRST_HOLD_TICKS: first_hold_ticks_reg <= pwdata[15:0];
                bdlpr_pkg::REG_REPEAT_TICKS:     repeat_ticks_reg     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bdlpr_pkg::REG_HANDLER_ENABLED:
                prdata = {{(bdlpr_pkg::DATA_W-1){1'b0}}, handler_enabled_reg};
            bdlpr_pkg::REG_DEBOUNCE_TICKS:
                prdata = {{(bdlpr_pkg::DATA_W-bdlpr_pkg::TICKS_W){1'b0}}, debounce_ticks_reg};
            bdlpr_pkg::REG_FIRST_HOLD_TICKS:
                prdata = {{(bdlpr_pkg::DATA_W-bdlpr_pkg::TICKS_W){1'b0}}, first_hold_ticks_reg};
            bdlpr_pkg::REG_REPEAT_TICKS:
                prdata = {{(bdlpr_pkg::DATA_W-bdlpr_pkg::TICKS_W){1'b0}}, repeat_ticks_reg};
            default:
                prdata = '0;
        endcase
    end

    // The command in the input register is evaluated when the output register can take
    // its result.
    assign advance        = !evt_valid_reg || !evt_stall;
    assign cmd_stall      = in_valid_reg && !advance;
    assign cmd_take       = cmd_valid && !cmd_stall;
    assign proc           = in_valid_reg && advance;
    assign in_valid_next  = cmd_take || (in_valid_reg && !advance);

    assign settling = (phase_reg == bdlpr_pkg::PH_SETTLE_DOWN) ||
                      (phase_reg == bdlpr_pkg::PH_SETTLE_UP);
    assign expiring = (in_word_reg.kind == bdlpr_pkg::KIND_TICK) && running_reg &&
                      (remaining_reg <= {{(bdlpr_pkg::TICKS_W-1){1'b0}}, 1'b1});

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        running_next   = running_reg;
        case (in_word_reg.kind)
            bdlpr_pkg::KIND_TICK:
            begin
                if (running_reg)
                begin
                    remaining_next = remaining_reg - {{(bdlpr_pkg::TICKS_W-1){1'b0}}, 1'b1};
                    if (expiring)
                    begin
                        running_next   = 1'b0;
                        remaining_next = '0;
                        if (settling)
                        begin
                            phase_next = in_word_reg.pin_level ? bdlpr_pkg::PH_UP
                                                               : bdlpr_pkg::PH_DOWN;
                            if (!in_word_reg.pin_level)
                            begin
                                remaining_next = period_of(first_hold_ticks_reg);
                                running_next   = 1'b1;
                            end
                        end
                        else if (phase_reg == bdlpr_pkg::PH_DOWN)
                        begin
                            remaining_next = period_of(repeat_ticks_reg);
                            running_next   = 1'b1;
                        end
                    end
                end
            end
            bdlpr_pkg::KIND_PIN:
            begin
                if (handler_enabled_reg)
                begin
                    if (phase_reg == bdlpr_pkg::PH_UP && !in_word_reg.pin_level)
                    begin
                        phase_next     = bdlpr_pkg::PH_SETTLE_DOWN;
                        remaining_next = period_of(debounce_ticks_reg);
                        running_next   = 1'b1;
                    end
                    else if (phase_reg == bdlpr_pkg::PH_DOWN && in_word_reg.pin_level)
                    begin
                        phase_next     = bdlpr_pkg::PH_SETTLE_UP;
                        remaining_next = period_of(debounce_ticks_reg);
                        running_next   = 1'b1;
                    end
                end
            end
            bdlpr_pkg::KIND_INIT:
            begin
                phase_next     = in_word_reg.pin_level ? bdlpr_pkg::PH_UP : bdlpr_pkg::PH_DOWN;
                remaining_next = '0;
                running_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        evt_fire = 1'b0;
        evt_word.event_level = in_word_reg.pin_level;
        evt_word.event_kind  = settling ? bdlpr_pkg::EVT_PRESS : bdlpr_pkg::EVT_REPEAT;
        if (expiring && handler_enabled_reg)
        begin
            if (settling)
            begin
                evt_fire = !in_word_reg.pin_level;
            end
            else
            begin
                evt_fire = (phase_reg == bdlpr_pkg::PH_DOWN);
            end
        end
    end

    assign evt_valid_next = proc ? evt_fire : (evt_valid_reg && evt_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            evt_valid_reg <= 1'b0;
            phase_reg     <= bdlpr_pkg::PH_UP;
            remaining_reg <= '0;
            running_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            evt_valid_reg <= evt_valid_next;
            if (proc)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                running_reg   <= running_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_word_reg <= cmd_data;
        end
        if (proc && evt_fire)
        begin
            evt_data_reg <= evt_word;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_data_reg;

    `BDLPR_ASSERT_ALWAYS(a_running_nonzero, running_reg |-> (remaining_reg != '0), "countdown running at zero")
    `BDLPR_ASSERT_ALWAYS(a_settle_timed, ((phase_reg == bdlpr_pkg::PH_SETTLE_DOWN) || (phase_reg == bdlpr_pkg::PH_SETTLE_UP)) |-> running_reg, "settling without countdown")
    `BDLPR_ASSERT(a_stall_only_full, cmd_stall |-> (in_valid_reg && evt_valid_reg), "stall with room to spare")
    `BDLPR_ASSERT(a_event_rearms, (proc && evt_fire) |=> ((phase_reg == bdlpr_pkg::PH_DOWN) && running_reg), "event without held phase and armed countdown")

endmodule

### tb/tb.sv
module tb;
    import bdlpr_pkg::*;

    localparam kind_t KIND_UNUSED = kind_t'(2'd3);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    cmd_t                cmd_data  = '0;
    logic                evt_valid;
    logic                evt_stall = 1'b0;
    evt_t                evt_data;

    cmd_t   pending_words[$];
    evt_t   event_queue[$];
    int     mismatches = 0;
    int     words_queued = 0;

    // Button model state and its copy of the registers.
    phase_t              btn_state  = PH_UP;
    logic [TICKS_W-1:0]  count_left = '0;
    logic                timer_on   = 1'b0;
    logic                cfg_enable = 1'b0;
    logic [TICKS_W-1:0]  cfg_settle = DEBOUNCE_RESET;
    logic [TICKS_W-1:0]  cfg_hold   = FIRST_HOLD_RESET;
    logic [TICKS_W-1:0]  cfg_repeat = REPEAT_RESET;

    int     burst_left = 0;
    int     gap_left   = 0;
    bit     hold_off_req = 1'b0;
    bit     hold_taken   = 1'b0;
    int     hold_left    = 0;
    int     stall_mode   = 0;
    int     mode_left    = 0;
    int     stall_count  = 0;

    button_debounce_long_press_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic arm_timer(logic [TICKS_W-1:0] period);
        count_left = (period == '0) ? TICKS_W'(1) : period;
        timer_on = 1'b1;
    endtask

    task automatic predict_word(cmd_t w);
        evt_t                ev;
        logic [TICKS_W-1:0]  next_period;
        ev.event_level = w.pin_level;
        ev.event_kind = EVT_REPEAT;
        next_period = cfg_repeat;
        case (w.kind)
            KIND_TICK:
            begin
                if (timer_on)
                begin
                    if (count_left != '0)
                        count_left = count_left - 1'b1;
                    if (count_left == '0)
                    begin
                        timer_on = 1'b0;
                        if (btn_state == PH_SETTLE_DOWN || btn_state == PH_SETTLE_UP)
                        begin
                            btn_state = w.pin_level ? PH_UP : PH_DOWN;
                            next_period = cfg_hold;
                            ev.event_kind = EVT_PRESS;
                        end
                        if (btn_state == PH_DOWN)
                        begin
                            arm_timer(next_period);
                            if (cfg_enable)
                                event_queue.push_back(ev);
                        end
                    end
                end
            end
            KIND_PIN:
            begin
                if (cfg_enable)
                begin
                    if (btn_state == PH_UP && !w.pin_level)
                    begin
                        btn_state = PH_SETTLE_DOWN;
                        arm_timer(cfg_settle);
                    end
                    else if (btn_state == PH_DOWN && w.pin_level)
                    begin
                        btn_state = PH_SETTLE_UP;
                        arm_timer(cfg_settle);
                    end
                end
            end
            KIND_INIT:
            begin
                btn_state = w.pin_level ? PH_UP : PH_DOWN;
                timer_on = 1'b0;
                count_left = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                predict_word(cmd_data);
                void'(pending_words.pop_front());
            end
            if (!(cmd_valid && cmd_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data <= pending_words[0];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request.
    always @(posedge clk)
    begin
        stall_count++;
        if (!rst_n)
            evt_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            evt_stall <= 1'b1;
        end
        else if (hold_off_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = 300;
            evt_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0: evt_stall <= 1'b0;
                1: evt_stall <= ($urandom_range(0, 2) == 0);
                default: evt_stall <= (stall_count % 5 >= 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (event_queue.size() == 0)
                report_mismatch($sformatf("event word %b with none pending", evt_data));
            else
            begin
                want = event_queue.pop_front();
                if (evt_data.event_level !== want.event_level)
                    report_mismatch($sformatf("event_level got %b want %b",
                                              evt_data.event_level, want.event_level));
                if (evt_data.event_kind !== want.event_kind)
                    report_mismatch($sformatf("event_kind got %b want %b",
                                              evt_data.event_kind, want.event_kind));
            end
        end
    end

    task automatic reg_write(reg_index_t idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HANDLER_ENABLED:  cfg_enable = val[0];
            REG_DEBOUNCE_TICKS:   cfg_settle = val[TICKS_W-1:0];
            REG_FIRST_HOLD_TICKS: cfg_hold = val[TICKS_W-1:0];
            default:              cfg_repeat = val[TICKS_W-1:0];
        endcase
    endtask

    function automatic logic [DATA_W-1:0] with_noise(logic [TICKS_W-1:0] v);
        return {16'($urandom), v};
    endfunction

    function automatic logic [TICKS_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return TICKS_W'($urandom_range(1, 5));
    endfunction

    task automatic push_word(kind_t k, logic lvl);
        cmd_t w;
        w.kind = k;
        w.pin_level = lvl;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic settle_idle();
        while (pending_words.size() != 0 || event_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int start;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no consumer, so the edge is ignored.
        push_word(KIND_PIN, 1'b0);
        push_word(KIND_TICK, 1'b0);
        settle_idle();

        reg_write(REG_HANDLER_ENABLED, {31'($urandom), 1'b1});
        reg_write(REG_DEBOUNCE_TICKS, with_noise(16'd2));
        reg_write(REG_FIRST_HOLD_TICKS, with_noise(16'd3));
        reg_write(REG_REPEAT_TICKS, with_noise(16'd1));
        push_word(KIND_UNUSED, 1'b0);
        push_word(KIND_UNUSED, 1'b1);
        push_word(KIND_INIT, 1'b1);
        push_word(KIND_TICK, 1'b1);
        push_word(KIND_PIN, 1'b0);
        push_word(KIND_PIN, 1'b1);
        push_word(KIND_TICK, 1'b0);
        push_word(KIND_TICK, 1'b0);
        repeat (3) push_word(KIND_TICK, 1'b0);
        push_word(KIND_TICK, 1'b1);
        push_word(KIND_PIN, 1'b1);
        repeat (2) push_word(KIND_TICK, 1'b1);
        push_word(KIND_TICK, 1'b1);
        push_word(KIND_PIN, 1'b0);
        push_word(KIND_TICK, 1'b0);
        push_word(KIND_TICK, 1'b1);
        push_word(KIND_INIT, 1'b0);
        push_word(KIND_TICK, 1'b0);
        push_word(KIND_PIN, 1'b1);
        repeat (2) push_word(KIND_TICK, 1'b0);
        settle_idle();

        // The timer keeps running with the consumer gone, but reports nothing.
        reg_write(REG_HANDLER_ENABLED, {31'($urandom), 1'b0});
        repeat (4) push_word(KIND_TICK, 1'b0);
        push_word(KIND_PIN, 1'b1);
        settle_idle();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 2)
            begin
                reg_write(REG_HANDLER_ENABLED, {31'($urandom), 1'b1});
                reg_write(REG_DEBOUNCE_TICKS, with_noise(16'd1));
                reg_write(REG_FIRST_HOLD_TICKS, with_noise(16'd1));
                reg_write(REG_REPEAT_TICKS, with_noise(16'd1));
                hold_off_req = 1'b1;
            end
            else
            begin
                reg_write(REG_HANDLER_ENABLED,
                          {31'($urandom), (p != 4) && ($urandom_range(0, 5) != 0)});
                reg_write(REG_DEBOUNCE_TICKS, with_noise(pick_period()));
                reg_write(REG_FIRST_HOLD_TICKS, with_noise(pick_period()));
                reg_write(REG_REPEAT_TICKS, with_noise(pick_period()));
            end
            start = words_queued;
            while (words_queued - start < 85)
            begin
                r = $urandom_range(0, 9);
                if (r <= 5)
                begin
                    push_word(KIND_PIN, 1'b0);
                    n = $urandom_range(0, 14);
                    repeat (n) push_word(KIND_TICK, $urandom_range(0, 7) == 0);
                    push_word(KIND_PIN, 1'b1);
                    n = $urandom_range(0, 8);
                    repeat (n) push_word(KIND_TICK, $urandom_range(0, 7) != 0);
                end
                else if (r <= 7)
                    push_word(kind_t'($urandom_range(0, 3)), 1'($urandom));
                else if (r == 8)
                    push_word(KIND_INIT, 1'($urandom));
                else
                begin
                    push_word(KIND_PIN, 1'b0);
                    push_word(KIND_PIN, 1'b1);
                    push_word(KIND_TICK, 1'($urandom));
                end
            end
            settle_idle();
        end

        // Largest periods everywhere; nothing expires in this short stretch.
        reg_write(REG_HANDLER_ENABLED, {31'($urandom), 1'b1});
        reg_write(REG_DEBOUNCE_TICKS, with_noise('1));
        reg_write(REG_FIRST_HOLD_TICKS, with_noise('1));
        reg_write(REG_REPEAT_TICKS, with_noise('1));
        push_word(KIND_INIT, 1'b1);
        push_word(KIND_PIN, 1'b0);
        repeat (5) push_word(KIND_TICK, 1'b0);
        push_word(KIND_INIT, 1'b1);
        settle_idle();

        // Zero debounce and repeat act as one tick; a short first hold leads into repeats.
        reg_write(REG_DEBOUNCE_TICKS, with_noise('0));
        reg_write(REG_FIRST_HOLD_TICKS, with_noise(16'd4));
        reg_write(REG_REPEAT_TICKS, with_noise('0));
        push_word(KIND_PIN, 1'b0);
        push_word(KIND_TICK, 1'b0);
        repeat (3) push_word(KIND_TICK, 1'b0);
        push_word(KIND_TICK, 1'b0);
        repeat (3) push_word(KIND_TICK, 1'b0);
        push_word(KIND_TICK, 1'b1);
        settle_idle();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("button_debounce_long_press_repeat verification clean");
        else
            $display("button_debounce_long_press_repeat verification failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("button_debounce_long_press_repeat verification failed");
        $finish;
    end

endmodule
